// File: rtl/core/rv32_pkg.sv
// Package for the RV32I execute block: opcodes, decoded request type, status codes.
// Used by rv32_front, rv32_back and the top level in rtl/core; depends on nothing.
`timescale 1ns / 1ps
package rv32_pkg;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;

  localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;
  localparam logic [6:0]  F7_ALT     = 7'h20;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef enum logic [1:0] {
    EX_IDLE,
    EX_READ,
    EX_MEM
  } ex_state_t;

  // One classified request travelling from the front to the back.
  typedef struct packed {
    logic [31:0] instr;
    logic        illegal;
  } dec_req_t;

endpackage

// File: rtl/core/rv32_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module rv32_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/rv32_front.sv
// Front part: accepts instruction words, classifies legality, feeds a two-entry queue.
// Depends on rv32_pkg.
`timescale 1ns / 1ps
module rv32_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          instruction,
  output logic                 q_valid,
  input  logic                 q_ready,
  output rv32_pkg::dec_req_t   q_data
);
  import rv32_pkg::*;

  dec_req_t   slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       illegal;
  logic [6:0] opc, f7;
  logic [2:0] f3;

  assign opc = instruction[6:0];
  assign f3  = instruction[14:12];
  assign f7  = instruction[31:25];

  always_comb begin
    unique case (opc)
      OP_LUI, OP_AUIPC, OP_JAL: illegal = 1'b0;
      OP_JALR:   illegal = (f3 != 3'd0);
      OP_BRANCH: illegal = (f3 == 3'd2) || (f3 == 3'd3);
      OP_LOAD:   illegal = (f3 == 3'd3) || (f3 > 3'd5);
      OP_STORE:  illegal = (f3 > 3'd2);
      OP_IMM: begin
        if (f3 == 3'd1) illegal = (f7 != 7'd0);
        else if (f3 == 3'd5) illegal = (f7 != 7'd0) && (f7 != F7_ALT);
        else illegal = 1'b0;
      end
      OP_REG: begin
        if (f7 == 7'd0) illegal = 1'b0;
        else if (f7 == F7_ALT) illegal = (f3 != 3'd0) && (f3 != 3'd5);
        else illegal = 1'b1;
      end
      default: illegal = 1'b1;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_data   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slot[wr_ptr].instr   <= instruction;
      slot[wr_ptr].illegal <= illegal;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (q_valid && q_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule

// File: rtl/core/rv32_back.sv
// Back part: reads registers, executes, accesses data memory, writes back.
// Depends on rv32_pkg and rv32_ram.
`timescale 1ns / 1ps
module rv32_back #(
  parameter int DMEM_WORDS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_pc,
  input  logic               q_valid,
  output logic               q_ready,
  input  rv32_pkg::dec_req_t q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [31:0]        next_pc,
  output logic               reg_written,
  output logic [4:0]         dest_index,
  output logic [31:0]        dest_value,
  output logic               mem_stored,
  output logic [31:0]        mem_address
);
  import rv32_pkg::*;

  localparam int AW = $clog2(DMEM_WORDS);
  localparam logic [32:0] MEM_BYTES = 33'(DMEM_WORDS) * 33'd4;

  ex_state_t state, state_next;
  logic [31:0] pc;
  dec_req_t    req;
  logic [31:0] rs1_q, rs2_q;
  logic [30:0] rf_valid;
  logic [31:0] addr_q;
  logic        range_ok_q;
  logic        accept;

  // After reset every data memory word in both banks is written with zero.
  logic          clearing;
  logic [AW-1:0] clr_cnt;

  // register file: two copies of a RAM, one per read port
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] rf_wdata, rf_a_raw, rf_b_raw;
  logic [4:0]  ra_a, ra_b;
  logic [4:0]  rs1_q_idx, rs2_q_idx;

  // The RAM read at the accepting edge misses a write-back at that same edge,
  // so the last write is registered and forwarded.
  logic        wb_we_q;
  logic [4:0]  wb_idx_q;
  logic [31:0] wb_val_q;

  assign ra_a = q_data.instr[19:15];
  assign ra_b = q_data.instr[24:20];

  rv32_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(ra_a), .rdata(rf_a_raw));
  rv32_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(ra_b), .rdata(rf_b_raw));

  // data memory is split into two word-interleaved banks so a misaligned
  // access spanning two words reads both in the same cycle
  logic [AW-1:0] dm_raddr0, dm_raddr1, dm_waddr0, dm_waddr1;
  logic [31:0]   dm_rdata0, dm_rdata1, dm_wdata0, dm_wdata1;
  logic          dm_we0, dm_we1;

  rv32_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dm0 (
    .clk(clk), .we(dm_we0), .waddr(dm_waddr0), .wdata(dm_wdata0),
    .raddr(dm_raddr0), .rdata(dm_rdata0));
  rv32_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dm1 (
    .clk(clk), .we(dm_we1), .waddr(dm_waddr1), .wdata(dm_wdata1),
    .raddr(dm_raddr1), .rdata(dm_rdata1));

  // Operands as read in the EX_READ state.
  logic [31:0] a_rd, b_rd;
  always_comb begin
    if (rs1_q_idx == 5'd0) a_rd = 32'd0;
    else if (wb_we_q && wb_idx_q == rs1_q_idx) a_rd = wb_val_q;
    else if (rf_valid[rs1_q_idx - 5'd1]) a_rd = rf_a_raw;
    else a_rd = 32'd0;
  end
  always_comb begin
    if (rs2_q_idx == 5'd0) b_rd = 32'd0;
    else if (wb_we_q && wb_idx_q == rs2_q_idx) b_rd = wb_val_q;
    else if (rf_valid[rs2_q_idx - 5'd1]) b_rd = rf_b_raw;
    else b_rd = 32'd0;
  end

  // Operands held for the EX_MEM state.
  logic [31:0] a, b;
  assign a = rs1_q;
  assign b = rs2_q;

  logic [31:0] ins, iimm, simm, bimm, jimm, sum_a;
  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [4:0]  rd;
  assign ins  = req.instr;
  assign opc  = ins[6:0];
  assign f3   = ins[14:12];
  assign f7   = ins[31:25];
  assign rd   = ins[11:7];
  assign iimm = {{20{ins[31]}}, ins[31:20]};
  assign simm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign bimm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign jimm = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign sum_a = a_rd + ((opc == OP_STORE) ? simm : iimm);

  logic [2:0]  nbytes;
  assign nbytes = (f3[1:0] == 2'd0) ? 3'd1 : ((f3[1:0] == 2'd1) ? 3'd2 : 3'd4);

  // word indexes of the first and second word touched; the address is formed
  // in EX_READ and held while the request waits in EX_MEM
  logic [31:0] w0, w1;
  logic [31:0] base_w;
  assign base_w = {2'b00, (state == EX_READ) ? sum_a[31:2] : addr_q[31:2]};
  assign w0 = base_w;
  assign w1 = base_w + 32'd1;

  // bank0 holds even words, bank1 odd ones
  logic [AW-1:0] even_idx, odd_idx;
  always_comb begin
    if (w0[0] == 1'b0) begin
      even_idx = AW'(w0);
      odd_idx  = AW'(w1);
    end else begin
      even_idx = AW'(w1);
      odd_idx  = AW'(w0);
    end
  end
  assign dm_raddr0 = even_idx;
  assign dm_raddr1 = odd_idx;

  logic [31:0] mw0, mw1;
  logic [AW-1:0] even_q, odd_q;
  logic          swap_q;
  always_ff @(posedge clk) begin
    even_q <= even_idx;
    odd_q  <= odd_idx;
    swap_q <= w0[0];
  end
  assign mw0  = swap_q ? dm_rdata1 : dm_rdata0;
  assign mw1  = swap_q ? dm_rdata0 : dm_rdata1;

  logic [63:0] pair, shifted, merged, wmask, wbits;
  logic [31:0] ldv, ld;
  assign pair    = {mw1, mw0};
  assign shifted = pair >> {addr_q[1:0], 3'b000};
  assign ldv     = shifted[31:0];
  always_comb begin
    unique case (f3)
      3'd0:    ld = {{24{ldv[7]}}, ldv[7:0]};
      3'd1:    ld = {{16{ldv[15]}}, ldv[15:0]};
      3'd4:    ld = {24'd0, ldv[7:0]};
      3'd5:    ld = {16'd0, ldv[15:0]};
      default: ld = ldv;
    endcase
  end
  always_comb begin
    unique case (f3[1:0])
      2'd0:    wmask = 64'h0000_0000_0000_00FF;
      2'd1:    wmask = 64'h0000_0000_0000_FFFF;
      default: wmask = 64'h0000_0000_FFFF_FFFF;
    endcase
  end
  assign wbits  = ({32'd0, b} & wmask) << {addr_q[1:0], 3'b000};
  assign merged = (pair & ~(wmask << {addr_q[1:0], 3'b000})) | wbits;

  // ALU and branch
  logic [31:0] opb, alu;
  logic [4:0]  sh;
  logic        lt_s, lt_u, take;
  assign opb  = (opc == OP_REG) ? b : iimm;
  assign sh   = opb[4:0];
  assign lt_s = $signed(a) < $signed(opb);
  assign lt_u = a < opb;
  always_comb begin
    unique case (f3)
      3'd0: alu = (opc == OP_REG && f7 == F7_ALT) ? a - opb : a + opb;
      3'd1: alu = a << sh;
      3'd2: alu = {31'd0, lt_s};
      3'd3: alu = {31'd0, lt_u};
      3'd4: alu = a ^ opb;
      3'd5: alu = (f7 == F7_ALT) ? 32'($signed(a) >>> sh) : a >> sh;
      3'd6: alu = a | opb;
      default: alu = a & opb;
    endcase
  end
  always_comb begin
    unique case (f3)
      3'd0: take = (a == b);
      3'd1: take = (a != b);
      3'd4: take = $signed(a) < $signed(b);
      3'd5: take = !($signed(a) < $signed(b));
      3'd6: take = a < b;
      3'd7: take = a >= b;
      default: take = 1'b0;
    endcase
  end

  logic [1:0]  r_status;
  logic [31:0] r_npc, r_val, r_addr;
  logic        r_wr, r_st;
  logic        finish;
  always_comb begin
    r_status = ST_OK;
    r_npc    = pc + 32'd4;
    r_val    = 32'd0;
    r_addr   = 32'd0;
    r_wr     = 1'b0;
    r_st     = 1'b0;
    if (req.illegal) begin
      r_status = ST_ILLEGAL;
    end else begin
      unique case (opc)
        OP_LUI:   begin r_val = ins & UPPER_MASK; r_wr = 1'b1; end
        OP_AUIPC: begin r_val = pc + (ins & UPPER_MASK); r_wr = 1'b1; end
        OP_JAL:   begin r_val = pc + 32'd4; r_wr = 1'b1; r_npc = pc + jimm; end
        OP_JALR:  begin r_val = pc + 32'd4; r_wr = 1'b1; r_npc = addr_q & ~32'd1; end
        OP_BRANCH: if (take) r_npc = pc + bimm;
        OP_LOAD: begin
          r_addr = addr_q;
          if (!range_ok_q) r_status = ST_RANGE;
          else begin r_val = ld; r_wr = 1'b1; end
        end
        OP_STORE: begin
          r_addr = addr_q;
          if (!range_ok_q) r_status = ST_RANGE;
          else r_st = 1'b1;
        end
        default: begin r_val = alu; r_wr = 1'b1; end
      endcase
    end
    if (r_status != ST_OK) begin
      r_npc = pc;
      r_wr  = 1'b0;
      r_st  = 1'b0;
    end
    if (!(r_wr && rd != 5'd0)) begin
      r_wr  = 1'b0;
      r_val = 32'd0;
    end
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign finish   = (state == EX_MEM) && out_free;
  assign accept   = q_valid && q_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      EX_IDLE: if (accept) state_next = EX_READ;
      EX_READ: state_next = EX_MEM;
      EX_MEM:  if (out_free) state_next = accept ? EX_READ : EX_IDLE;
      default: state_next = EX_IDLE;
    endcase
  end

  always_comb begin
    q_ready = !clearing && ((state == EX_IDLE) || finish);
  end

  assign rf_we    = finish && r_wr;
  assign rf_waddr = rd;
  assign rf_wdata = r_val;
  assign dm_we0    = clearing || (finish && r_st);
  assign dm_we1    = dm_we0;
  assign dm_waddr0 = clearing ? clr_cnt : even_q;
  assign dm_waddr1 = clearing ? clr_cnt : odd_q;
  assign dm_wdata0 = clearing ? 32'd0 : (swap_q ? merged[63:32] : merged[31:0]);
  assign dm_wdata1 = clearing ? 32'd0 : (swap_q ? merged[31:0] : merged[63:32]);

  always_ff @(posedge clk) begin
    wb_idx_q <= rf_waddr;
    wb_val_q <= rf_wdata;
    if (accept) begin
      req       <= q_data;
      rs1_q_idx <= ra_a;
      rs2_q_idx <= ra_b;
    end
    if (state == EX_READ) begin
      rs1_q      <= a_rd;
      rs2_q      <= b_rd;
      addr_q     <= sum_a;
      range_ok_q <= ({1'b0, sum_a} + {30'd0, nbytes}) <= MEM_BYTES;
    end
    if (finish) begin
      status      <= r_status;
      next_pc     <= r_npc;
      reg_written <= r_wr;
      dest_index  <= r_wr ? rd : 5'd0;
      dest_value  <= r_val;
      mem_stored  <= r_st;
      mem_address <= r_addr;
    end
    if (rst) begin
      state     <= EX_IDLE;
      pc        <= 32'd0;
      out_valid <= 1'b0;
      rf_valid  <= '0;
      wb_we_q   <= 1'b0;
      clearing  <= 1'b1;
      clr_cnt   <= '0;
    end else begin
      state   <= state_next;
      wb_we_q <= rf_we;
      if (cfg_we) pc <= cfg_pc;
      else if (finish) pc <= r_npc;
      if (finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (rf_we) rf_valid[rd - 5'd1] <= 1'b1;
      if (clearing) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (clr_cnt == AW'(DMEM_WORDS - 1)) clearing <= 1'b0;
      end
    end
  end
endmodule

// File: rtl/core/rv32i_instruction_execute.sv
// Top level of the RV32I execute block: front classifier, request queue, back executor.
// Depends on rv32_pkg, rv32_front, rv32_back, rv32_ram.
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | instruction
//  out     | out_valid / out_ready| status, next_pc, reg_written, dest_index, dest_value,
//          |                      | mem_stored, mem_address
//  cfg     | start_pc_we          | start_pc
//
// A request passes through two back-end states: EX_READ reads the register file and forms
// the address, EX_MEM has the data memory words in hand and registers the result once the
// output is free; the back end takes the next request only as the previous one finishes.
// After reset the back end writes zeros to every data memory word before it takes the
// first request; the pc resets to 0 and registers read as zero until written.
// A two-entry queue lets the front accept up to two requests while the back or the output stalls.
`timescale 1ns / 1ps
module rv32i_instruction_execute #(
  parameter int DMEM_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start_pc_we,
  input  logic [31:0] start_pc,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instruction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] next_pc,
  output logic        reg_written,
  output logic [4:0]  dest_index,
  output logic [31:0] dest_value,
  output logic        mem_stored,
  output logic [31:0] mem_address
);
  import rv32_pkg::*;

  logic     q_valid, q_ready;
  dec_req_t q_data;

  rv32_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .instruction(instruction), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data));

  rv32_back #(.DMEM_WORDS(DMEM_WORDS)) u_back (
    .clk(clk), .rst(rst), .cfg_we(start_pc_we), .cfg_pc(start_pc),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .next_pc(next_pc),
    .reg_written(reg_written), .dest_index(dest_index), .dest_value(dest_value),
    .mem_stored(mem_stored), .mem_address(mem_address));
endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for rv32i_instruction_execute: directed and random RV32I requests.
// Holds its own register file, pc and data memory to predict every result; uses rv32_pkg.
`timescale 1ns / 1ps
module tb;
  import rv32_pkg::*;

  localparam int MEM_WORDS = 1024;
  localparam int MEM_BYTES = MEM_WORDS * 4;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        mem_stored;
    logic [31:0] mem_address;
  } retire_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start_pc_we = 1'b0;
  logic [31:0] start_pc = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] instruction = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] next_pc;
  logic        reg_written;
  logic [4:0]  dest_index;
  logic [31:0] dest_value;
  logic        mem_stored;
  logic [31:0] mem_address;

  rv32i_instruction_execute #(.DMEM_WORDS(MEM_WORDS)) uut (
    .clk(clk), .rst(rst), .start_pc_we(start_pc_we), .start_pc(start_pc),
    .in_valid(in_valid), .in_ready(in_ready), .instruction(instruction),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .next_pc(next_pc),
    .reg_written(reg_written), .dest_index(dest_index), .dest_value(dest_value),
    .mem_stored(mem_stored), .mem_address(mem_address)
  );

  always #4 clk = ~clk;

  // Shadow architectural state.
  logic [31:0] gpr [1:31];
  logic [31:0] pc_q;
  logic [7:0]  dmem [0:MEM_BYTES-1];

  retire_t pending[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int sink_hold = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, checked);
    errors++;
  endtask

  function automatic logic [31:0] rd_gpr(input logic [4:0] i);
    return (i == 0) ? 32'd0 : gpr[i];
  endfunction

  function automatic logic slt_s(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic retire_t execute(input logic [31:0] ins);
    retire_t r;
    logic [6:0] opc, f7;
    logic [4:0] rd;
    logic [2:0] f3;
    logic [31:0] a, b, iimm, pc, npc, val, addr, v;
    logic wr, stored, take;
    logic [1:0] st;
    int n;
    opc = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12]; f7 = ins[31:25];
    a = rd_gpr(ins[19:15]); b = rd_gpr(ins[24:20]);
    iimm = {{20{ins[31]}}, ins[31:20]};
    pc = pc_q; npc = pc + 4; val = 0; addr = 0; wr = 0; stored = 0; st = ST_OK;
    case (opc)
      OP_LUI: begin val = ins & UPPER_MASK; wr = 1; end
      OP_AUIPC: begin val = pc + (ins & UPPER_MASK); wr = 1; end
      OP_JAL: begin
        val = pc + 4; wr = 1;
        npc = pc + {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
      end
      OP_JALR: begin
        if (f3 != 0) st = ST_ILLEGAL;
        else begin val = pc + 4; wr = 1; npc = (a + iimm) & ~32'd1; end
      end
      OP_BRANCH: begin
        take = 0;
        case (f3)
          3'd0: take = a == b;
          3'd1: take = a != b;
          3'd4: take = slt_s(a, b);
          3'd5: take = !slt_s(a, b);
          3'd6: take = a < b;
          3'd7: take = a >= b;
          default: st = ST_ILLEGAL;
        endcase
        if (take) npc = pc + {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
      end
      OP_LOAD: begin
        if (f3 == 3 || f3 > 5) st = ST_ILLEGAL;
        else begin
          n = 1 << f3[1:0];
          addr = a + iimm;
          if ({32'd0, addr} + n > MEM_BYTES) st = ST_RANGE;
          else begin
            v = 0;
            for (int k = 0; k < n; k++) v |= 32'(dmem[addr + k]) << (8 * k);
            if (f3 == 0) v = {{24{v[7]}}, v[7:0]};
            else if (f3 == 1) v = {{16{v[15]}}, v[15:0]};
            val = v; wr = 1;
          end
        end
      end
      OP_STORE: begin
        if (f3 > 2) st = ST_ILLEGAL;
        else begin
          n = 1 << f3;
          addr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
          if ({32'd0, addr} + n > MEM_BYTES) st = ST_RANGE;
          else begin
            for (int k = 0; k < n; k++) dmem[addr + k] = b[8*k +: 8];
            stored = 1;
          end
        end
      end
      OP_IMM: begin
        wr = 1;
        case (f3)
          3'd0: val = a + iimm;
          3'd1: begin if (f7 != 0) st = ST_ILLEGAL; val = a << ins[24:20]; end
          3'd2: val = 32'(slt_s(a, iimm));
          3'd3: val = 32'(a < iimm);
          3'd4: val = a ^ iimm;
          3'd5: begin
            if (f7 == 0) val = a >> ins[24:20];
            else if (f7 == F7_ALT) val = $signed(a) >>> ins[24:20];
            else st = ST_ILLEGAL;
          end
          3'd6: val = a | iimm;
          default: val = a & iimm;
        endcase
      end
      OP_REG: begin
        wr = 1;
        if (f7 == F7_ALT) begin
          if (f3 == 0) val = a - b;
          else if (f3 == 5) val = $signed(a) >>> b[4:0];
          else st = ST_ILLEGAL;
        end else if (f7 == 0) begin
          case (f3)
            3'd0: val = a + b;
            3'd1: val = a << b[4:0];
            3'd2: val = 32'(slt_s(a, b));
            3'd3: val = 32'(a < b);
            3'd4: val = a ^ b;
            3'd5: val = a >> b[4:0];
            3'd6: val = a | b;
            default: val = a & b;
          endcase
        end else st = ST_ILLEGAL;
      end
      default: st = ST_ILLEGAL;
    endcase
    if (st != ST_OK) begin
      npc = pc; wr = 0; stored = 0;
      if (st == ST_ILLEGAL) addr = 0;
    end
    if (wr && rd != 0) gpr[rd] = val;
    else begin wr = 0; rd = 0; val = 0; end
    pc_q = npc;
    r.status = st; r.next_pc = npc; r.reg_written = wr; r.dest_index = rd;
    r.dest_value = val; r.mem_stored = stored; r.mem_address = addr;
    return r;
  endfunction

  task automatic clear_state();
    for (int i = 1; i < 32; i++) gpr[i] = 0;
    for (int i = 0; i < MEM_BYTES; i++) dmem[i] = 0;
    pc_q = 0;
  endtask

  // Valid stays high between back-to-back requests; it drops only before an idle gap.
  task automatic send_request(input logic [31:0] ins);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    instruction <= ins;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending.push_back(execute(ins));
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_start_pc(input logic [31:0] value);
    drain();
    start_pc_we <= 1'b1;
    start_pc <= value;
    @(posedge clk);
    start_pc_we <= 1'b0;
    pc_q = value;
  endtask

  // Result checker with random backpressure.
  always @(posedge clk) begin
    retire_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending.size() == 0) begin
          report("unexpected result", 32'd0, 32'd0);
        end else begin
          want = pending.pop_front();
          if (status !== want.status) report("status", 32'(status), 32'(want.status));
          if (next_pc !== want.next_pc) report("next_pc", next_pc, want.next_pc);
          if (reg_written !== want.reg_written)
            report("reg_written", 32'(reg_written), 32'(want.reg_written));
          if (dest_index !== want.dest_index)
            report("dest_index", 32'(dest_index), 32'(want.dest_index));
          if (dest_value !== want.dest_value) report("dest_value", dest_value, want.dest_value);
          if (mem_stored !== want.mem_stored)
            report("mem_stored", 32'(mem_stored), 32'(want.mem_stored));
          if (mem_address !== want.mem_address)
            report("mem_address", mem_address, want.mem_address);
          checked++;
        end
      end
      if (sink_hold > 0) begin
        sink_hold <= sink_hold - 1;
        out_ready <= 1'b0;
      end else if (out_ready && out_valid && $urandom_range(0, 2) != 0) begin
        sink_hold <= $urandom_range(0, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] enc_i(input logic [6:0] opc, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

  function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [12:0] off);
    return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OP_BRANCH};
  endfunction

  function automatic logic [4:0] rreg();
    return 5'($urandom_range(0, 31));
  endfunction

  // Random instruction weighted toward legal forms with addresses near memory.
  function automatic logic [31:0] rand_instr();
    logic [2:0] f3;
    logic [6:0] f7;
    f3 = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 19))
      0: return {$urandom()} & UPPER_MASK | 32'(OP_LUI) | (32'(rreg()) << 7);
      1: return {$urandom()} & UPPER_MASK | 32'(OP_AUIPC) | (32'(rreg()) << 7);
      2: return {$urandom()} & ~32'h7F | 32'(OP_JAL);
      3: return enc_i(OP_JALR, ($urandom_range(0, 7) == 0) ? f3 : 3'd0, rreg(), rreg(),
                      12'($urandom()));
      4, 5: return enc_b(f3, rreg(), rreg(), 13'($urandom()));
      6, 7, 8: return enc_i(OP_LOAD, 3'($urandom_range(0, 5)), rreg(), 5'($urandom_range(0, 3)),
                            ($urandom_range(0, 9) == 0) ? 12'($urandom())
                                                        : 12'($urandom_range(0, 2047)));
      9, 10, 11: return enc_s(3'($urandom_range(0, 2)), 5'($urandom_range(0, 3)), rreg(),
                              ($urandom_range(0, 9) == 0) ? 12'($urandom())
                                                          : 12'($urandom_range(0, 2047)));
      12: return enc_i(OP_IMM, 3'd0, 5'($urandom_range(1, 3)), 5'd0, 12'($urandom_range(0, 4095)));
      13, 14, 15: begin
        f7 = ($urandom_range(0, 1) == 0) ? 7'd0 : F7_ALT;
        if ($urandom_range(0, 15) == 0) f7 = 7'($urandom());
        if (f3 == 1 || f3 == 5) return {f7, rreg(), rreg(), f3, rreg(), OP_IMM};
        return enc_i(OP_IMM, f3, rreg(), rreg(), 12'($urandom()));
      end
      16, 17, 18: begin
        f7 = ($urandom_range(0, 1) == 0) ? 7'd0 : F7_ALT;
        if ($urandom_range(0, 15) == 0) f7 = 7'($urandom());
        return enc_r(f7, f3, rreg(), rreg(), rreg());
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    send_request(enc_i(OP_IMM, 3'd0, 5'd1, 5'd0, 12'h7FF));
    send_request(enc_i(OP_IMM, 3'd0, 5'd2, 5'd0, 12'h800));
    send_request(32'hFFFFF000 | 32'(OP_LUI) | (5'd31 << 7));
    send_request(32'h12345000 | 32'(OP_AUIPC) | (5'd3 << 7));
    send_request(enc_i(OP_IMM, 3'd0, 5'd0, 5'd1, 12'h001));     // write to x0 dropped
    send_request(enc_r(F7_ALT, 3'd0, 5'd4, 5'd0, 5'd1));
    send_request(enc_r(F7_ALT, 3'd5, 5'd5, 5'd2, 5'd1));
    send_request(enc_i(OP_IMM, 3'd3, 5'd6, 5'd1, 12'hFFF));     // sltiu vs sign-extended imm
    send_request(enc_b(3'd6, 5'd1, 5'd2, 13'h1FFC));            // bltu taken, backward
    send_request(enc_b(3'd4, 5'd2, 5'd1, 13'h0FFE));
    send_request(enc_s(3'd2, 5'd0, 5'd31, 12'h7FE));            // misaligned word store
    send_request(enc_i(OP_LOAD, 3'd0, 5'd7, 5'd0, 12'h7FF));
    send_request(enc_i(OP_LOAD, 3'd5, 5'd8, 5'd0, 12'h7FE));
    send_request(enc_s(3'd2, 5'd2, 5'd1, 12'h000));             // wraps far out of range
    send_request(enc_i(OP_LOAD, 3'd2, 5'd9, 5'd2, 12'h7FF));    // range fault
    send_request(enc_i(OP_LOAD, 3'd3, 5'd9, 5'd0, 12'h000));    // illegal funct3
    send_request(enc_r(7'h01, 3'd0, 5'd9, 5'd1, 5'd2));         // illegal funct7
    send_request({7'h20, 5'd3, 5'd1, 3'd1, 5'd9, OP_IMM});      // illegal slli
    send_request(enc_i(OP_JALR, 3'd0, 5'd10, 5'd1, 12'h7FF));   // clears bit 0 only
    send_request(32'h8000_0000 | 32'(OP_JAL) | (5'd11 << 7));
    send_request(32'hFFFF_FFFF);
    send_request(32'h0000_0000);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_request(rand_instr());
      // Occasionally let the whole pipeline empty before continuing.
      if ($urandom_range(0, 199) == 0) begin
        in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
      end
    end
  endtask

  task automatic test_start_pc();
    load_start_pc(32'hFFFF_FFFC);
    send_request(enc_i(OP_IMM, 3'd0, 5'd1, 5'd1, 12'h001));
    send_request(32'h12345000 | 32'(OP_AUIPC) | (5'd3 << 7));
    load_start_pc(32'h0000_0000);
    test_random(30);
    load_start_pc($urandom());
  endtask

  initial begin
    clear_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_start_pc();
    test_random(900);
    load_start_pc(32'hFFFF_FFFF);
    test_random(900);
    drain();
    $display("tb: %0d requests sent, %0d results checked over directed, start-pc and random phases",
             sent, checked);
    if (errors == 0 && pending.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("tb: timeout with %0d results outstanding", pending.size());
    $display("tb: done, errors");
    $finish;
  end
endmodule
